// ===== rtl/tafd_pkg.sv =====
// ----------------------------------------------------------------------------
// tafd_pkg: shared definitions for the thermal average fire detector
// Sizes of the reading ring and averaging window, register indexes, reset
// values and the controller state type.
// ----------------------------------------------------------------------------
package tafd_pkg;

  // Ring and window sizing.
  localparam int RING_DEPTH = 10;
  localparam int WINDOW     = 5;
  localparam int WIN_LEN    = (WINDOW > RING_DEPTH) ? RING_DEPTH :
                              ((WINDOW < 1) ? 1 : WINDOW);

  // Field widths.
  localparam int AMB_IN_W  = 8;
  localparam int OBJ_IN_W  = 10;
  localparam int AMB_W     = 7;
  localparam int OBJ_W     = 9;
  localparam int TICK_W    = 9;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int ENTRY_W   = AMB_W + OBJ_W;

  // Derived widths.
  localparam int SLOT_W  = $clog2(RING_DEPTH);
  localparam int SEEN_W  = $clog2(WIN_LEN + 1);
  localparam int SUM_W   = $clog2(WIN_LEN * (2 ** OBJ_W));
  localparam int DCNT_W  = $clog2(TICK_W + 1);

  // Window mean by reciprocal multiplication: floor(sum * MEAN_MUL / 2^MEAN_SH)
  // equals floor(sum / WIN_LEN) for every sum below 2^SUM_W.
  localparam int MEAN_SH     = SUM_W + $clog2(WIN_LEN);
  localparam int MEAN_MUL_W  = MEAN_SH + 1;
  localparam int MEAN_PROD_W = SUM_W + MEAN_MUL_W;
  localparam logic [MEAN_MUL_W-1:0] MEAN_MUL =
    MEAN_MUL_W'((2 ** MEAN_SH + WIN_LEN - 1) / WIN_LEN);

  // Ambient saturation limit of the unsigned binary ambient field.
  localparam logic [AMB_W-1:0] AMB_MAX = AMB_W'(99);

  // Register reset values.
  localparam logic [CFG_W-1:0] THRESHOLD_RST = CFG_W'(1);
  localparam logic [CFG_W-1:0] INT_FIRED_RST = CFG_W'(1);
  localparam logic [CFG_W-1:0] INT_IDLE_RST  = CFG_W'(4);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRE_THRESHOLD = 2'd0,
    CFG_INTERVAL_FIRED = 2'd1,
    CFG_INTERVAL_IDLE  = 2'd2
  } cfg_idx_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_WRITE,
    ST_READ,
    ST_LAST,
    ST_DIV_AMB,
    ST_DIV_OBJ,
    ST_FIRE
  } state_e;

endpackage

// ===== rtl/thermal_average_fire_detect.sv =====
// ----------------------------------------------------------------------------
// thermal_average_fire_detect: moving average and fire threshold detector
// Takes one tick per transaction, samples ambient and object temperature at
// the active interval, averages the newest readings from a ring memory and
// flags the cooktop as fired when object exceeds ambient by the threshold.
// ----------------------------------------------------------------------------
// The block takes one tick at a time. A tick with an odd count finishes in
// the cycle it is accepted. Any other tick runs the remainder check against
// the active interval through a serial divider, one quotient bit per cycle.
// A tick that takes no reading then returns to idle. A reading tick writes
// the ring; before the window is full it goes straight to the fire
// decision. With a full window it reads the newest WIN_LEN entries over the
// single ring read port, forms the two means by reciprocal multiplication
// and makes the fire decision. The fire decision waits while the previous
// result is still held in the output register; a finished result waits
// there while the next tick is taken.
// ----------------------------------------------------------------------------
module thermal_average_fire_detect (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Configuration write port
  input  logic                                    cfg_we_i,
  input  logic [tafd_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [tafd_pkg::CFG_W-1:0]              cfg_wdata_i,
  // Input channel
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [tafd_pkg::AMB_IN_W-1:0]    ambient_temp_i,
  input  logic signed [tafd_pkg::OBJ_IN_W-1:0]    object_temp_i,
  input  logic                                    link_connected_i,
  // Output channel
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [tafd_pkg::OBJ_W-1:0]              object_avg_o,
  output logic [tafd_pkg::AMB_W-1:0]              ambient_avg_o,
  output logic                                    is_fired_o
);

  // Configuration registers
  logic [tafd_pkg::CFG_W-1:0] threshold_q;
  logic [tafd_pkg::CFG_W-1:0] int_fired_q;
  logic [tafd_pkg::CFG_W-1:0] int_idle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= tafd_pkg::THRESHOLD_RST;
      int_fired_q <= tafd_pkg::INT_FIRED_RST;
      int_idle_q  <= tafd_pkg::INT_IDLE_RST;
    end else if (cfg_we_i) begin
      case (tafd_pkg::cfg_idx_e'(cfg_idx_i))
        tafd_pkg::CFG_FIRE_THRESHOLD: threshold_q <= cfg_wdata_i;
        tafd_pkg::CFG_INTERVAL_FIRED: int_fired_q <= cfg_wdata_i;
        tafd_pkg::CFG_INTERVAL_IDLE:  int_idle_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Declarations
  tafd_pkg::state_e state_q, state_d;

  logic [tafd_pkg::TICK_W-1:0]  tick_q;
  logic [tafd_pkg::TICK_W-1:0]  tick_nxt_q;
  logic [tafd_pkg::TICK_W-1:0]  tick_inc;
  logic                         fired_q;
  logic [tafd_pkg::SLOT_W-1:0]  slot_q;
  logic [tafd_pkg::SEEN_W-1:0]  seen_q;
  logic [tafd_pkg::SEEN_W-1:0]  seen_inc;
  logic                         win_full;

  logic [tafd_pkg::AMB_W-1:0]   amb_rd_q;
  logic [tafd_pkg::OBJ_W-1:0]   obj_rd_q;
  logic                         conn_q;
  logic [tafd_pkg::AMB_W-1:0]   amb_clamp;
  logic [tafd_pkg::OBJ_W-1:0]   obj_clamp;

  logic [tafd_pkg::SLOT_W-1:0]  rd_ptr_q;
  logic [tafd_pkg::SEEN_W-1:0]  rd_cnt_q;
  logic                         rd_vld_q;
  logic [tafd_pkg::ENTRY_W-1:0] rd_data_q;
  logic [tafd_pkg::SUM_W-1:0]   sum_amb_q, sum_obj_q;
  logic [tafd_pkg::SUM_W-1:0]   sum_amb_nxt, sum_obj_nxt;

  logic [tafd_pkg::SUM_W-1:0]       mean_src;
  logic [tafd_pkg::MEAN_PROD_W-1:0] mean_prod;
  logic [tafd_pkg::OBJ_W-1:0]       mean_quo;

  logic [tafd_pkg::AMB_W-1:0]   res_amb_q;
  logic [tafd_pkg::OBJ_W-1:0]   res_obj_q;

  logic [tafd_pkg::CFG_W-1:0]   interval_raw;
  logic [tafd_pkg::CFG_W-1:0]   interval;
  logic                         fire_now;

  logic                         div_load;
  logic [tafd_pkg::TICK_W-1:0]  div_quo_q;
  logic [tafd_pkg::CFG_W-1:0]   div_rem_q;
  logic [tafd_pkg::CFG_W-1:0]   div_dvs_q;
  logic [tafd_pkg::DCNT_W-1:0]  div_cnt_q;
  logic                         div_done;
  logic [tafd_pkg::CFG_W:0]     div_part;
  logic                         div_ge;

  logic                         in_acc;
  logic                         out_load;
  logic                         ring_we;

  logic [tafd_pkg::ENTRY_W-1:0] ring_mem [tafd_pkg::RING_DEPTH];

  // Input conditioning: clamp at zero, saturate ambient
  always_comb begin
    if (ambient_temp_i[tafd_pkg::AMB_IN_W-1]) begin
      amb_clamp = '0;
    end else if (ambient_temp_i > $signed({1'b0, tafd_pkg::AMB_MAX})) begin
      amb_clamp = tafd_pkg::AMB_MAX;
    end else begin
      amb_clamp = ambient_temp_i[tafd_pkg::AMB_W-1:0];
    end
    obj_clamp = object_temp_i[tafd_pkg::OBJ_IN_W-1] ? '0 :
                object_temp_i[tafd_pkg::OBJ_W-1:0];
  end

  // Active interval; a zero register acts as one.
  assign interval_raw = fired_q ? int_fired_q : int_idle_q;
  assign interval     = (interval_raw == '0) ? tafd_pkg::CFG_W'(1) : interval_raw;
  assign tick_inc     = tick_q + tafd_pkg::TICK_W'(1);
  assign seen_inc     = (seen_q < tafd_pkg::SEEN_W'(tafd_pkg::WIN_LEN)) ?
                        seen_q + tafd_pkg::SEEN_W'(1) : seen_q;
  assign win_full     = (seen_inc == tafd_pkg::SEEN_W'(tafd_pkg::WIN_LEN));

  assign in_acc   = in_valid_i && in_ready_o;
  assign div_done = (div_cnt_q == '0);

  // Window sums including the entry arriving from the ring this cycle.
  assign sum_amb_nxt = sum_amb_q + (rd_vld_q ?
    tafd_pkg::SUM_W'(rd_data_q[tafd_pkg::ENTRY_W-1 -: tafd_pkg::AMB_W]) : '0);
  assign sum_obj_nxt = sum_obj_q + (rd_vld_q ?
    tafd_pkg::SUM_W'(rd_data_q[tafd_pkg::OBJ_W-1:0]) : '0);

  // Window mean by reciprocal multiplication, ambient first, then object.
  assign mean_src  = (state_q == tafd_pkg::ST_DIV_AMB) ? sum_amb_q : sum_obj_q;
  assign mean_prod = tafd_pkg::MEAN_PROD_W'(mean_src) *
                     tafd_pkg::MEAN_PROD_W'(tafd_pkg::MEAN_MUL);
  assign mean_quo  = mean_prod[tafd_pkg::MEAN_SH +: tafd_pkg::OBJ_W];

  // Fire decision on the new reading, or on the window means once the window is full.
  assign fire_now = ($signed({2'b00, res_obj_q}) - $signed({4'b0000, res_amb_q}))
                    > $signed({3'b000, threshold_q});

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tafd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and control outputs
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_load   = 1'b0;
    out_load   = 1'b0;
    ring_we    = 1'b0;
    case (state_q)
      tafd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && !tick_inc[0]) begin
          div_load = 1'b1;
          state_d  = tafd_pkg::ST_MOD;
        end
      end
      tafd_pkg::ST_MOD: begin
        if (div_done) begin
          state_d = (div_rem_q == '0) ? tafd_pkg::ST_WRITE : tafd_pkg::ST_IDLE;
        end
      end
      tafd_pkg::ST_WRITE: begin
        ring_we = 1'b1;
        state_d = win_full ? tafd_pkg::ST_READ : tafd_pkg::ST_FIRE;
      end
      tafd_pkg::ST_READ: begin
        if (rd_cnt_q == tafd_pkg::SEEN_W'(tafd_pkg::WIN_LEN - 1)) begin
          state_d = tafd_pkg::ST_LAST;
        end
      end
      tafd_pkg::ST_LAST: begin
        state_d = tafd_pkg::ST_DIV_AMB;
      end
      tafd_pkg::ST_DIV_AMB: begin
        state_d = tafd_pkg::ST_DIV_OBJ;
      end
      tafd_pkg::ST_DIV_OBJ: begin
        state_d = tafd_pkg::ST_FIRE;
      end
      tafd_pkg::ST_FIRE: begin
        if (!conn_q) begin
          state_d = tafd_pkg::ST_IDLE;
        end else if (!out_valid_o || out_ready_i) begin
          out_load = 1'b1;
          state_d  = tafd_pkg::ST_IDLE;
        end
      end
      default: state_d = tafd_pkg::ST_IDLE;
    endcase
  end

  // Serial restoring divider for the interval remainder, one bit per cycle
  assign div_part = {div_rem_q, div_quo_q[tafd_pkg::TICK_W-1]};
  assign div_ge   = (div_part >= {1'b0, div_dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (div_load) begin
      div_cnt_q <= tafd_pkg::DCNT_W'(tafd_pkg::TICK_W);
    end else if (!div_done) begin
      div_cnt_q <= div_cnt_q - tafd_pkg::DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_load) begin
      div_quo_q <= tick_inc;
      div_rem_q <= '0;
      div_dvs_q <= interval;
    end else if (!div_done) begin
      div_quo_q <= {div_quo_q[tafd_pkg::TICK_W-2:0], div_ge};
      div_rem_q <= div_ge ? tafd_pkg::CFG_W'(div_part - {1'b0, div_dvs_q}) :
                            div_part[tafd_pkg::CFG_W-1:0];
    end
  end

  // Tick counter, ring pointer, fill count and fired flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      slot_q  <= '0;
      seen_q  <= '0;
      fired_q <= 1'b1;
    end else begin
      if (in_acc && tick_inc[0]) begin
        tick_q <= tick_inc;
      end
      if (state_q == tafd_pkg::ST_MOD && div_done) begin
        tick_q <= (div_rem_q == '0) ? '0 : tick_nxt_q;
      end
      if (ring_we) begin
        slot_q <= (slot_q == tafd_pkg::SLOT_W'(tafd_pkg::RING_DEPTH - 1)) ? '0 :
                  slot_q + tafd_pkg::SLOT_W'(1);
        seen_q <= seen_inc;
      end
      if (state_q == tafd_pkg::ST_FIRE && (!conn_q || out_load)) begin
        fired_q <= fire_now;
      end
    end
  end

  // Captured tick payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tick_nxt_q <= tick_inc;
      amb_rd_q   <= amb_clamp;
      obj_rd_q   <= obj_clamp;
      conn_q     <= link_connected_i;
    end
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[slot_q] <= {amb_rd_q, obj_rd_q};
    end
    rd_data_q <= ring_mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == tafd_pkg::ST_READ);
    end
  end

  // Window walk from the newest entry backwards, with running sums
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      rd_ptr_q  <= slot_q;
      rd_cnt_q  <= '0;
      sum_amb_q <= '0;
      sum_obj_q <= '0;
      res_amb_q <= amb_rd_q;
      res_obj_q <= obj_rd_q;
    end else begin
      if (state_q == tafd_pkg::ST_READ) begin
        rd_ptr_q <= (rd_ptr_q == '0) ? tafd_pkg::SLOT_W'(tafd_pkg::RING_DEPTH - 1) :
                    rd_ptr_q - tafd_pkg::SLOT_W'(1);
        rd_cnt_q <= rd_cnt_q + tafd_pkg::SEEN_W'(1);
      end
      sum_amb_q <= sum_amb_nxt;
      sum_obj_q <= sum_obj_nxt;
      if (state_q == tafd_pkg::ST_DIV_AMB) begin
        res_amb_q <= mean_quo[tafd_pkg::AMB_W-1:0];
      end
      if (state_q == tafd_pkg::ST_DIV_OBJ) begin
        res_obj_q <= mean_quo;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      object_avg_o  <= res_obj_q;
      ambient_avg_o <= res_amb_q;
      is_fired_o    <= fire_now;
    end
  end

  // Assertions
  a_div_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_cnt_q != '0) |-> (state_q == tafd_pkg::ST_MOD))
    else $error("divider busy outside the remainder state");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < tafd_pkg::SLOT_W'(tafd_pkg::RING_DEPTH))
    else $error("ring write pointer out of range");

  a_seen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= tafd_pkg::SEEN_W'(tafd_pkg::WIN_LEN))
    else $error("fill count beyond window length");

  a_amb_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tafd_pkg::ST_FIRE) |-> (res_amb_q <= tafd_pkg::AMB_MAX))
    else $error("ambient result above saturation limit");

  a_out_from_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == tafd_pkg::ST_FIRE && conn_q))
    else $error("result presented without a connected reading");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for thermal_average_fire_detect
// Drives ticks through the valid/ready input channel, keeps its own copy of
// the sampling counter, reading rings and fired flag, and compares every
// reading that leaves the block with the value computed here.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Quiet cycles allowed for a tick that is still in flight, and the stall
  // limit of the watchdog.
  localparam int BUSY_CYCLES    = tafd_pkg::TICK_W + tafd_pkg::WIN_LEN + 24;
  localparam int WATCHDOG_LIMIT = 4000;

  // One averaged reading as it leaves the block.
  typedef struct packed {
    logic [tafd_pkg::OBJ_W-1:0] object_avg;
    logic [tafd_pkg::AMB_W-1:0] ambient_avg;
    logic                       is_fired;
  } reading_t;

  logic                                 clk_i;
  logic                                 rst_ni           = 1'b0;
  logic                                 cfg_we_i         = 1'b0;
  logic [tafd_pkg::CFG_IDX_W-1:0]       cfg_idx_i        = '0;
  logic [tafd_pkg::CFG_W-1:0]           cfg_wdata_i      = '0;
  logic                                 in_valid_i       = 1'b0;
  logic                                 in_ready_o;
  logic signed [tafd_pkg::AMB_IN_W-1:0] ambient_temp_i   = '0;
  logic signed [tafd_pkg::OBJ_IN_W-1:0] object_temp_i    = '0;
  logic                                 link_connected_i = 1'b0;
  logic                                 out_valid_o;
  logic                                 out_ready_i      = 1'b0;
  logic [tafd_pkg::OBJ_W-1:0]           object_avg_o;
  logic [tafd_pkg::AMB_W-1:0]           ambient_avg_o;
  logic                                 is_fired_o;

  // Register copies kept by the testbench.
  logic [tafd_pkg::CFG_W-1:0] threshold_reg      = tafd_pkg::THRESHOLD_RST;
  logic [tafd_pkg::CFG_W-1:0] fired_interval_reg = tafd_pkg::INT_FIRED_RST;
  logic [tafd_pkg::CFG_W-1:0] idle_interval_reg  = tafd_pkg::INT_IDLE_RST;

  // Averager state kept by the testbench.
  logic [tafd_pkg::AMB_W-1:0]  amb_ring [tafd_pkg::RING_DEPTH] = '{default: '0};
  logic [tafd_pkg::OBJ_W-1:0]  obj_ring [tafd_pkg::RING_DEPTH] = '{default: '0};
  int unsigned                 write_slot          = 0;
  int unsigned                 readings_seen       = 0;
  logic [tafd_pkg::TICK_W-1:0] ticks_since_reading = '0;
  logic                        fired_now           = 1'b1;

  reading_t expected_avgs[$];
  int       mismatch_count = 0;
  int       idle_cycles    = 0;
  bit       burst_mode     = 1'b0;

  thermal_average_fire_detect dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .ambient_temp_i   (ambient_temp_i),
    .object_temp_i    (object_temp_i),
    .link_connected_i (link_connected_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .object_avg_o     (object_avg_o),
    .ambient_avg_o    (ambient_avg_o),
    .is_fired_o       (is_fired_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Advances the averager by one tick and queues the reading it sends, if any.
  function automatic void step_averager(input int amb, input int obj, input logic link);
    int unsigned interval;
    int unsigned sum_amb;
    int unsigned sum_obj;
    int unsigned idx;
    int          amb_v;
    int          obj_v;
    reading_t    r;
    interval = fired_now ? fired_interval_reg : idle_interval_reg;
    if (interval == 0) begin
      interval = 1;
    end
    ticks_since_reading = ticks_since_reading + 1'b1;
    if (ticks_since_reading[0] || (ticks_since_reading % interval) != 0) begin
      return;
    end
    ticks_since_reading = '0;

    // Clamp at zero, saturate ambient at the display limit.
    amb_v = (amb < 0) ? 0 : ((amb > int'(tafd_pkg::AMB_MAX)) ?
                             int'(tafd_pkg::AMB_MAX) : amb);
    obj_v = (obj < 0) ? 0 : obj;
    amb_ring[write_slot] = amb_v[tafd_pkg::AMB_W-1:0];
    obj_ring[write_slot] = obj_v[tafd_pkg::OBJ_W-1:0];
    write_slot = (write_slot + 1) % tafd_pkg::RING_DEPTH;
    if (readings_seen < tafd_pkg::WIN_LEN) begin
      readings_seen++;
    end

    // Once the window is full, the reading becomes the truncated mean.
    if (readings_seen >= tafd_pkg::WIN_LEN) begin
      sum_amb = 0;
      sum_obj = 0;
      for (int i = 0; i < tafd_pkg::WIN_LEN; i++) begin
        idx = (write_slot + tafd_pkg::RING_DEPTH - 1 - i) % tafd_pkg::RING_DEPTH;
        sum_amb += amb_ring[idx];
        sum_obj += obj_ring[idx];
      end
      amb_v = sum_amb / tafd_pkg::WIN_LEN;
      obj_v = sum_obj / tafd_pkg::WIN_LEN;
    end

    fired_now = ((obj_v - amb_v) > int'(threshold_reg));
    if (link) begin
      r.object_avg  = obj_v[tafd_pkg::OBJ_W-1:0];
      r.ambient_avg = amb_v[tafd_pkg::AMB_W-1:0];
      r.is_fired    = fired_now;
      expected_avgs.push_back(r);
    end
  endfunction

  // Prints one mismatch line and counts it.
  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Writes one register; the block is idle whenever this is called.
  task automatic write_reg(input tafd_pkg::cfg_idx_e idx,
                           input logic [tafd_pkg::CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      tafd_pkg::CFG_FIRE_THRESHOLD: threshold_reg      = value;
      tafd_pkg::CFG_INTERVAL_FIRED: fired_interval_reg = value;
      tafd_pkg::CFG_INTERVAL_IDLE:  idle_interval_reg  = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sends one tick and returns at the edge where the transaction completes.
  task automatic send_tick(input int amb, input int obj, input logic link);
    while (!burst_mode && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    ambient_temp_i   <= amb[tafd_pkg::AMB_IN_W-1:0];
    object_temp_i    <= obj[tafd_pkg::OBJ_IN_W-1:0];
    link_connected_i <= link;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    step_averager(amb, obj, link);
  endtask

  // Sends a tick with random content, often close to the fire margin.
  task automatic send_random_tick();
    int amb;
    int obj;
    amb = int'($urandom_range(191)) - 64;
    if ($urandom_range(99) < 30) begin
      obj = ((amb < 0) ? 0 : amb) + int'(threshold_reg) + int'($urandom_range(4)) - 2;
      obj = (obj > 511) ? 511 : obj;
    end else begin
      obj = int'($urandom_range(639)) - 128;
    end
    send_tick(amb, obj, ($urandom_range(99) < 75));
  endtask

  // Holds the input off until every reading has come out and the block is quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_avgs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (BUSY_CYCLES) @(posedge clk_i);
  endtask

  // Extremes of every input field under the reset register values.
  task automatic test_field_extremes();
    int amb_list [12] = '{127, -64, 100, 99, -1, 0, 127, 50, -64, 98, 127, 0};
    int obj_list [12] = '{511, -128, 0, -1, 511, 0, 300, 52, 511, 200, -128, 511};
    bit link_list[12] = '{1, 1, 1, 1, 1, 0, 0, 1, 1, 1, 1, 1};
    for (int i = 0; i < 12; i++) begin
      send_tick(amb_list[i], obj_list[i], link_list[i]);
    end
  endtask

  // Interval registers at zero act as one; zero fire margin.
  task automatic test_zero_interval();
    settle();
    write_reg(tafd_pkg::CFG_FIRE_THRESHOLD, 8'd0);
    write_reg(tafd_pkg::CFG_INTERVAL_FIRED, 8'd0);
    write_reg(tafd_pkg::CFG_INTERVAL_IDLE, 8'd0);
    for (int i = 0; i < 8; i++) begin
      send_tick(40, 39 + (i % 3), 1'b1);
    end
  endtask

  // Drives the tick counter to 509 at the widest interval, then narrows the
  // interval so that no multiple is met before the counter wraps to zero.
  task automatic test_counter_wrap();
    settle();
    write_reg(tafd_pkg::CFG_INTERVAL_FIRED, 8'd255);
    write_reg(tafd_pkg::CFG_INTERVAL_IDLE, 8'd255);
    while (ticks_since_reading != tafd_pkg::TICK_W'(509)) begin
      send_random_tick();
    end
    settle();
    write_reg(tafd_pkg::CFG_INTERVAL_FIRED, 8'd254);
    write_reg(tafd_pkg::CFG_INTERVAL_IDLE, 8'd254);
    repeat (3) send_tick(int'($urandom_range(99)), int'($urandom_range(511)), 1'b1);
  endtask

  // Random ticks in phases of register settings; the first phase never idles.
  task automatic test_random_phases();
    int sent;
    int count;
    int phase;
    sent  = 0;
    phase = 0;
    while (sent < 1050) begin
      settle();
      if (phase == 1) begin
        write_reg(tafd_pkg::CFG_FIRE_THRESHOLD, 8'd255);
        write_reg(tafd_pkg::CFG_INTERVAL_FIRED, 8'd2);
        write_reg(tafd_pkg::CFG_INTERVAL_IDLE, 8'd1);
      end else if (phase == 2) begin
        write_reg(tafd_pkg::CFG_FIRE_THRESHOLD, 8'd0);
        write_reg(tafd_pkg::CFG_INTERVAL_FIRED, 8'd1);
        write_reg(tafd_pkg::CFG_INTERVAL_IDLE, 8'd3);
      end else begin
        if (phase == 0 || $urandom_range(99) < 70) begin
          write_reg(tafd_pkg::CFG_FIRE_THRESHOLD, ($urandom_range(1) != 0) ?
                    tafd_pkg::CFG_W'($urandom_range(20)) :
                    tafd_pkg::CFG_W'($urandom_range(255)));
        end
        if (phase == 0 || $urandom_range(99) < 70) begin
          write_reg(tafd_pkg::CFG_INTERVAL_FIRED, ($urandom_range(99) < 85) ?
                    tafd_pkg::CFG_W'($urandom_range(6)) :
                    tafd_pkg::CFG_W'($urandom_range(24, 7)));
        end
        if (phase == 0 || $urandom_range(99) < 70) begin
          write_reg(tafd_pkg::CFG_INTERVAL_IDLE, ($urandom_range(99) < 85) ?
                    tafd_pkg::CFG_W'($urandom_range(6)) :
                    tafd_pkg::CFG_W'($urandom_range(24, 7)));
        end
      end
      burst_mode = (phase == 0);
      count = (phase == 0) ? 300 : int'($urandom_range(110, 50));
      repeat (count) send_random_tick();
      sent += count;
      phase++;
    end
    burst_mode = 1'b0;
  endtask

  // Result receiver: random back-pressure, none during a burst.
  always @(posedge clk_i) begin
    out_ready_i <= burst_mode || ($urandom_range(99) >= 28);
  end

  // Compares each result transaction with the oldest pending reading.
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_avgs.size() == 0) begin
        flag_mismatch($sformatf("result obj=%0d amb=%0d fired=%0b with none pending",
                                object_avg_o, ambient_avg_o, is_fired_o));
      end else begin
        want = expected_avgs.pop_front();
        if (object_avg_o !== want.object_avg) begin
          flag_mismatch($sformatf("object_avg %0d, want %0d", object_avg_o, want.object_avg));
        end
        if (ambient_avg_o !== want.ambient_avg) begin
          flag_mismatch($sformatf("ambient_avg %0d, want %0d",
                                  ambient_avg_o, want.ambient_avg));
        end
        if (is_fired_o !== want.is_fired) begin
          flag_mismatch($sformatf("is_fired %0b, want %0b", is_fired_o, want.is_fired));
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction completes for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_zero_interval();
    test_counter_wrap();
    test_random_phases();
    settle();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
